### rtl/wmf_pkg.sv
// Shared constants and the pixel type for the window median filter.
// No dependencies.
package wmf_pkg;
    localparam int MaxImageWidth = 1024;
    localparam int MaxWinH       = 7;
    localparam int MaxWinW       = 7;
    localparam int LsRows        = (MaxWinH > 1) ? MaxWinH - 1 : 1;
    localparam int ColW          = $clog2(MaxImageWidth);
    localparam int RowW          = 12;
    localparam int WinCells      = MaxWinH * MaxWinW;
    localparam int CntW          = $clog2(WinCells + 1);

    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd2;
    localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd3;
    localparam logic [2:0] REG_CENTER_COL    = 3'd4;
    localparam logic [2:0] REG_CENTER_ROW    = 3'd5;

    typedef logic [7:0] pix_t;
endpackage

### rtl/window_median_filter.sv
// Top level of the streaming 2-D median filter over 8-bit gray pixels.
// Depends on wmf_pkg and wmf_rank_cell.
//
// Takes pixels in raster order and returns, for every pixel that completes a
// full window_height x window_width window, the median of that window tagged
// with the anchor's image row and column; border pixels yield nothing. Line
// buffers hold 6 rows of up to 1024 pixels; they need no clearing after reset.
// An item that yields no result takes the pixel and reads the line store,
// then shifts the window and ages the line store column. An item that yields
// a result does both, then loads the window into a chain of 49 rank
// cells, streams the window past the chain (one compare per cell per cycle),
// picks the middle ranks and loads the output register. The input is held
// off for all of that. Once the result sits in the output register the next
// pixel is taken; a second result waits in the load step until the first
// transaction has left.
module window_median_filter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [11:0]                cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  wmf_pkg::pix_t              pixel,
    input  logic                       frame_start,
    output logic                       out_valid,
    input  logic                       out_stall,
    output wmf_pkg::pix_t              median,
    output logic [11:0]                out_row,
    output logic [9:0]                 out_col,
    output logic                       frame_done
);
    import wmf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RANK = 2'd1;
    localparam logic [1:0] ST_PICK = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // configuration
    logic [10:0] iw_reg;
    logic [11:0] ih_reg;
    logic [2:0]  ww_reg, wh_reg, cx_reg, cy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iw_reg <= 11'd640;
            ih_reg <= 12'd480;
            ww_reg <= 3'd3;
            wh_reg <= 3'd3;
            cx_reg <= 3'd1;
            cy_reg <= 3'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   iw_reg <= cfg_data[10:0];
                REG_IMAGE_HEIGHT:  ih_reg <= cfg_data;
                REG_WINDOW_WIDTH:  ww_reg <= cfg_data[2:0];
                REG_WINDOW_HEIGHT: wh_reg <= cfg_data[2:0];
                REG_CENTER_COL:    cx_reg <= cfg_data[2:0];
                REG_CENTER_ROW:    cy_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // effective sizes: zero acts as one, oversize saturates
    logic [10:0] ew;
    logic [11:0] eh;
    logic [2:0]  ew_w, eh_w, ecx, ecy;
    always_comb
    begin
        ew   = (iw_reg == '0) ? 11'd1 : ((iw_reg > 11'(MaxImageWidth)) ?
               11'(MaxImageWidth) : iw_reg);
        eh   = (ih_reg == '0) ? 12'd1 : ih_reg;
        ew_w = (ww_reg == '0) ? 3'd1 : ww_reg;
        eh_w = (wh_reg == '0) ? 3'd1 : wh_reg;
        ecx  = (cx_reg < ew_w) ? cx_reg : ew_w - 3'd1;
        ecy  = (cy_reg < eh_w) ? cy_reg : eh_w - 3'd1;
    end

    // state
    logic [1:0]  state_reg, state_next;
    logic [11:0] row_reg;
    logic [10:0] col_reg;
    logic        out_valid_reg;
    pix_t        median_reg;
    logic [11:0] out_row_reg;
    logic [9:0]  out_col_reg;
    logic        frame_done_reg;

    logic accept;
    assign accept   = in_valid && !in_stall;

    // position of this pixel after start-of-frame and edge wrap
    logic [11:0] r0, r1, r;
    logic [10:0] c0, c;
    always_comb
    begin
        r0 = frame_start ? '0 : row_reg;
        c0 = frame_start ? '0 : col_reg;
        r1 = r0;
        c  = c0;
        if (c0 >= ew)
        begin
            c  = '0;
            r1 = r0 + 12'd1;
        end
        r = (r1 >= eh) ? '0 : r1;
    end
    logic [9:0] ci;
    assign ci = c[9:0];

    // window registers: update in the cycle after accept, from the read data
    pix_t win_reg [MaxWinH][MaxWinW];
    logic shift_reg;
    logic emit_reg;
    logic [11:0] er_reg;
    logic [9:0]  ec_reg;
    logic        efd_reg;

    // line store: one memory per row age, read at accept at column ci, then
    // aged at the same column in the shift cycle from the registered read data
    pix_t ls_mem [LsRows][MaxImageWidth];
    pix_t ls_rd  [LsRows];
    pix_t pix_d;
    logic [9:0] ci_reg;
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int a = 0; a < LsRows; a++)
                ls_rd[a] <= ls_mem[a][ci];
            pix_d  <= pixel;
            ci_reg <= ci;
        end
        if (shift_reg)
        begin
            ls_mem[0][ci_reg] <= pix_d;
            for (int a = 1; a < LsRows; a++)
                ls_mem[a][ci_reg] <= ls_rd[a-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < MaxWinH; a++)
                for (int l = 0; l < MaxWinW; l++)
                    win_reg[a][l] <= '0;
        end
        else if (shift_reg)
        begin
            for (int a = 0; a < MaxWinH; a++)
            begin
                for (int l = 0; l + 1 < MaxWinW; l++)
                    win_reg[a][l] <= win_reg[a][l+1];
                if (a == 0)
                    win_reg[a][MaxWinW-1] <= pix_d;
                else
                    win_reg[a][MaxWinW-1] <= ls_rd[a-1];
            end
        end
    end

    // window serialized over the rank chain, one entry per cycle
    logic [5:0] idx_reg;
    logic       load_cells;
    logic [CntW-1:0] n_act;
    assign n_act = CntW'(ew_w) * CntW'(eh_w);

    pix_t cell_val [WinCells];
    logic cell_act [WinCells];
    logic [CntW-1:0] cell_rank [WinCells];
    pix_t probe_val;
    logic probe_act;

    assign probe_val = cell_val[idx_reg];
    assign probe_act = cell_act[idx_reg];

    genvar g;
    generate
        for (g = 0; g < WinCells; g++)
        begin : g_cell
            localparam int GA = g / MaxWinW;
            localparam int GL = g % MaxWinW;
            logic act_l;
            assign act_l = (3'(GA) < eh_w) && (3'(GL) >= 3'(MaxWinW) - ew_w);
            wmf_rank_cell u_cell (
                .clk       (clk),
                .load      (load_cells),
                .step      (state_reg == ST_RANK),
                .load_val  (win_reg[GA][GL]),
                .load_act  (act_l),
                .probe_val (probe_val),
                .probe_act (probe_act),
                .probe_idx (idx_reg),
                .my_idx    (6'(g)),
                .val       (cell_val[g]),
                .act       (cell_act[g]),
                .rank      (cell_rank[g])
            );
        end
    endgenerate

    // middle ranks: lo = (n-1)/2, hi = n/2
    logic [CntW-1:0] rk_lo, rk_hi;
    pix_t m_lo, m_hi;
    always_comb
    begin
        rk_lo = (n_act - 1'b1) >> 1;
        rk_hi = n_act >> 1;
        m_lo  = '0;
        m_hi  = '0;
        for (int k = 0; k < WinCells; k++)
        begin
            if (cell_act[k] && cell_rank[k] == rk_lo) m_lo = cell_val[k];
            if (cell_act[k] && cell_rank[k] == rk_hi) m_hi = cell_val[k];
        end
    end
    pix_t lo_reg, hi_reg;

    // load the chain only once the window has taken the emitting pixel
    assign load_cells = emit_reg && !shift_reg && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (load_cells) state_next = ST_RANK;
            ST_RANK: if (idx_reg == 6'(WinCells - 1)) state_next = ST_PICK;
            ST_PICK: state_next = ST_OUT;
            ST_OUT:  if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // input side is stalled while a result is in flight, and in the cycle after
    // each accept to let the window pick up the line-store read
    logic busy_shift;
    assign busy_shift = shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            shift_reg     <= 1'b0;
            emit_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            shift_reg <= accept;
            if (accept)
            begin
                emit_reg <= (r >= 12'(eh_w) - 12'd1) && (c >= 11'(ew_w) - 11'd1);
                if (c + 11'd1 >= ew)
                begin
                    col_reg <= '0;
                    row_reg <= (r + 12'd1 >= eh) ? '0 : r + 12'd1;
                end
                else
                begin
                    col_reg <= c + 11'd1;
                    row_reg <= r;
                end
            end
            else if (load_cells)
                emit_reg <= 1'b0;
            if (state_reg == ST_RANK)
                idx_reg <= idx_reg + 6'd1;
            else
                idx_reg <= '0;
            if (state_reg == ST_OUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            er_reg  <= r - (12'(eh_w) - 12'd1) + 12'(ecy);
            ec_reg  <= 10'(c - (11'(ew_w) - 11'd1) + 11'(ecx));
            efd_reg <= (r == eh - 12'd1) && (c == ew - 11'd1);
        end
        if (state_reg == ST_PICK)
        begin
            lo_reg <= m_lo;
            hi_reg <= m_hi;
        end
        if (state_reg == ST_OUT && (!out_valid_reg || !out_stall))
        begin
            median_reg     <= 8'((9'(lo_reg) + 9'(hi_reg)) >> 1);
            out_row_reg    <= er_reg;
            out_col_reg    <= ec_reg;
            frame_done_reg <= efd_reg;
        end
    end

    // hold input off while a window shift or emit decision is pending
    logic stall_int;
    assign stall_int = busy_shift || emit_reg;
    assign in_stall  = (state_reg != ST_IDLE) || stall_int;

    assign out_valid  = out_valid_reg;
    assign median     = median_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign frame_done = frame_done_reg;
endmodule

### rtl/wmf_rank_cell.sv
// One cell of the rank chain: holds one window pixel, counts how many
// pixels of the window rank below it. Depends on wmf_pkg.
module wmf_rank_cell (
    input  logic                  clk,
    input  logic                  load,
    input  logic                  step,
    input  wmf_pkg::pix_t         load_val,
    input  logic                  load_act,
    input  wmf_pkg::pix_t         probe_val,
    input  logic                  probe_act,
    input  logic [5:0]            probe_idx,
    input  logic [5:0]            my_idx,
    output wmf_pkg::pix_t         val,
    output logic                  act,
    output logic [wmf_pkg::CntW-1:0] rank
);
    import wmf_pkg::*;
    pix_t val_reg;
    logic act_reg;
    logic [CntW-1:0] rank_reg;
    logic below;

    // Stable order: ties broken by index so ranks are a permutation.
    assign below = probe_act && ((probe_val < val_reg) ||
                   ((probe_val == val_reg) && (probe_idx < my_idx)));

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg  <= load_val;
            act_reg  <= load_act;
            rank_reg <= '0;
        end
        else if (step && below)
        begin
            rank_reg <= rank_reg + 1'b1;
        end
    end

    assign val  = val_reg;
    assign act  = act_reg;
    assign rank = rank_reg;
endmodule
